// ----- rtl/core/dfcm_pkg.sv -----
`timescale 1ns / 1ps

package dfcm_pkg;

  localparam int DEPTH_W   = 16;
  localparam int SQ_W      = 2 * DEPTH_W;
  localparam int CUBE_W    = 3 * DEPTH_W;
  localparam int SCALED_W  = CUBE_W + 4;
  localparam int COLOR_W   = 8;
  localparam int IDX_W     = 11;
  // level = scaled >> 23, index = level >> 5, level saturates at 2^16 - 1
  localparam int IDX_LSB   = 28;
  localparam int SAT_BIT   = 39;

  localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'd128;
  localparam logic [COLOR_W-1:0] ALPHA_CLEAR  = 8'd0;
  localparam logic [COLOR_W-1:0] COLOR_FULL   = 8'd255;
  localparam logic [COLOR_W-1:0] COLOR_NONE   = 8'd0;

  typedef enum logic [2:0] {
    BAND_WHITE_RED    = 3'd0,
    BAND_RED_YELLOW   = 3'd1,
    BAND_YELLOW_GREEN = 3'd2,
    BAND_GREEN_CYAN   = 3'd3,
    BAND_CYAN_BLUE    = 3'd4,
    BAND_BLUE_DARK    = 3'd5,
    BAND_CLEAR_LO     = 3'd6,
    BAND_CLEAR_HI     = 3'd7
  } band_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] alpha;
  } pix_t;

  function automatic pix_t palette(input logic [IDX_W-1:0] idx, input logic zero);
    pix_t p;
    logic [COLOR_W-1:0] lb;
    band_t band;
    lb      = idx[COLOR_W-1:0];
    band    = band_t'(idx[IDX_W-1:COLOR_W]);
    p.alpha = zero ? ALPHA_CLEAR : ALPHA_OPAQUE;
    case (band)
      BAND_WHITE_RED: begin
        p.red = COLOR_FULL; p.green = COLOR_FULL - lb; p.blue = COLOR_FULL - lb;
      end
      BAND_RED_YELLOW: begin
        p.red = COLOR_FULL; p.green = lb; p.blue = COLOR_NONE;
      end
      BAND_YELLOW_GREEN: begin
        p.red = COLOR_FULL - lb; p.green = COLOR_FULL; p.blue = COLOR_NONE;
      end
      BAND_GREEN_CYAN: begin
        p.red = COLOR_NONE; p.green = COLOR_FULL; p.blue = lb;
      end
      BAND_CYAN_BLUE: begin
        p.red = COLOR_NONE; p.green = COLOR_FULL - lb; p.blue = COLOR_FULL;
      end
      BAND_BLUE_DARK: begin
        p.red = COLOR_NONE; p.green = COLOR_NONE; p.blue = COLOR_FULL - lb;
      end
      default: begin
        p.red = COLOR_NONE; p.green = COLOR_NONE; p.blue = COLOR_NONE;
        p.alpha = ALPHA_CLEAR;
      end
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/core/dfcm_cube.sv -----
`timescale 1ns / 1ps

module dfcm_cube (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dfcm_pkg::DEPTH_W-1:0]   in_depth,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dfcm_pkg::CUBE_W-1:0]    out_cube,
  output logic                           out_zero
);

  logic                          v1_r, v2_r;
  logic [dfcm_pkg::SQ_W-1:0]     sq_r;
  logic [dfcm_pkg::DEPTH_W-1:0]  d1_r;
  logic                          zero1_r, zero2_r;
  logic [dfcm_pkg::CUBE_W-1:0]   cube_r;
  logic                          ready1, ready2;

  assign ready2   = !v2_r || out_ready;
  assign ready1   = !v1_r || ready2;
  assign in_ready = ready1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (ready1) v1_r <= in_valid;
      if (ready2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      sq_r    <= {{dfcm_pkg::DEPTH_W{1'b0}}, in_depth} *
                 {{dfcm_pkg::DEPTH_W{1'b0}}, in_depth};
      d1_r    <= in_depth;
      zero1_r <= (in_depth == '0);
    end
    if (ready2 && v1_r) begin
      cube_r  <= {{dfcm_pkg::DEPTH_W{1'b0}}, sq_r} * {{dfcm_pkg::SQ_W{1'b0}}, d1_r};
      zero2_r <= zero1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_cube  = cube_r;
  assign out_zero  = zero2_r;

endmodule

// ----- rtl/core/dfcm_palette.sv -----
`timescale 1ns / 1ps

module dfcm_palette (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dfcm_pkg::CUBE_W-1:0]  in_cube,
  input  logic                         in_zero,
  output logic                         out_valid,
  input  logic                         out_ready,
  output dfcm_pkg::pix_t               out_pix
);

  logic                           v3_r, v4_r;
  logic [dfcm_pkg::IDX_W-1:0]     idx_r;
  logic [dfcm_pkg::IDX_W-1:0]     idx_nxt;
  logic                           zero3_r;
  dfcm_pkg::pix_t                 pix_r;
  logic [dfcm_pkg::SCALED_W-1:0]  scaled;
  logic                           sat;
  logic                           ready3, ready4;

  // 9 * cube
  assign scaled  = {1'b0, in_cube, 3'b000} + {4'b0000, in_cube};
  assign sat     = |scaled[dfcm_pkg::SCALED_W-1:dfcm_pkg::SAT_BIT];
  assign idx_nxt = sat ? {dfcm_pkg::IDX_W{1'b1}}
                       : scaled[dfcm_pkg::SAT_BIT-1:dfcm_pkg::IDX_LSB];

  assign ready4   = !v4_r || out_ready;
  assign ready3   = !v3_r || ready4;
  assign in_ready = ready3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (ready3) v3_r <= in_valid;
      if (ready4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && in_valid) begin
      idx_r   <= idx_nxt;
      zero3_r <= in_zero;
    end
    if (ready4 && v3_r) begin
      pix_r <= dfcm_pkg::palette(idx_r, zero3_r);
    end
  end

  assign out_valid = v4_r;
  assign out_pix   = pix_r;

endmodule

// ----- rtl/core/depth_false_color_mapper.sv -----
`timescale 1ns / 1ps

// Depth to RGBA false-color mapper.
// Input channel: in_valid / in_stall with in_depth_mm, one depth item in mm,
// zero meaning no reading. Output channel: out_valid / out_stall with
// out_red, out_green, out_blue, out_alpha, one pixel per depth item.
// An item is taken on a clock edge where valid is high and stall is low.
// Level is the cubic gamma 9*d^3 >> 23, saturated; the palette index
// picks one of six color ramps, higher bands are transparent black.
// Alpha is 128, or 0 for zero depth and transparent bands.
// Pipeline: square, cube, scale/index, palette, one register each.
// Throughput: one item per cycle while out_stall is low, set by the two pipelined multipliers.
// Output stall: each stage holds its item; empty stages keep filling, so
// in_stall rises only once all four stages are occupied.
// Reset (rst_n low, synchronous) empties the pipeline; no other state.

module depth_false_color_mapper (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [dfcm_pkg::DEPTH_W-1:0]   in_depth_mm,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [dfcm_pkg::COLOR_W-1:0]   out_red,
  output logic [dfcm_pkg::COLOR_W-1:0]   out_green,
  output logic [dfcm_pkg::COLOR_W-1:0]   out_blue,
  output logic [dfcm_pkg::COLOR_W-1:0]   out_alpha
);

  logic                          in_ready;
  logic                          mid_valid, mid_ready;
  logic [dfcm_pkg::CUBE_W-1:0]   mid_cube;
  logic                          mid_zero;
  dfcm_pkg::pix_t                pix;

  dfcm_cube u_cube (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_depth  (in_depth_mm),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_cube  (mid_cube),
    .out_zero  (mid_zero)
  );

  dfcm_palette u_palette (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_cube   (mid_cube),
    .in_zero   (mid_zero),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_pix   (pix)
  );

  assign in_stall  = !in_ready;
  assign out_red   = pix.red;
  assign out_green = pix.green;
  assign out_blue  = pix.blue;
  assign out_alpha = pix.alpha;

  a_no_stall_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output stage");

  a_alpha_codes : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_alpha == dfcm_pkg::ALPHA_OPAQUE ||
                   out_alpha == dfcm_pkg::ALPHA_CLEAR))
    else $error("alpha outside its two codes");

  a_clear_colors : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_alpha == dfcm_pkg::ALPHA_CLEAR) |->
      ((out_red == dfcm_pkg::COLOR_FULL && out_green == dfcm_pkg::COLOR_FULL &&
        out_blue == dfcm_pkg::COLOR_FULL) ||
       (out_red == dfcm_pkg::COLOR_NONE && out_green == dfcm_pkg::COLOR_NONE &&
        out_blue == dfcm_pkg::COLOR_NONE)))
    else $error("clear pixel is neither white nor black");

endmodule
